// ===== rtl/lidar_time_to_collision_brake_assert.svh =====
// Assertion macros shared by the lidar time-to-collision brake RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LIDAR_TIME_TO_COLLISION_BRAKE_ASSERT_SVH
`define LIDAR_TIME_TO_COLLISION_BRAKE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LTTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lttc_pkg.sv =====
// Package for the lidar time-to-collision brake: sizes, register indexes,
// controller types and the quarter-wave cosine table. Depends on nothing.
package lttc_pkg;

    localparam int COS_TABLE_DEPTH = 256;
    localparam int MAX_BEAMS       = 4096;

    localparam int COS_IDX_W   = $clog2(COS_TABLE_DEPTH + 1);
    localparam int BEAM_CNT_W  = $clog2(MAX_BEAMS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int BEAM_IDX_W  = 12;
    localparam int RANGE_W     = 16;
    localparam int COS_W       = 15;
    localparam int LHS_W       = 26;   // range * 1000
    localparam int PROD_W      = 32;   // speed * cosine
    localparam int RHS_W       = 47;   // threshold * positive product
    localparam int ANGLE_FRAC_W = 14;  // angle bits below the quadrant
    localparam int MM_PER_M    = 1000;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Taylor denominators (2n-1)*(2n) for n = 1..9.
    typedef logic [63:0] t_div_list [0:8];
    localparam t_div_list TAYLOR_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                         64'd132, 64'd182, 64'd240, 64'd306};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_START   = 3'd0,
        CFG_ANGLE_STEP    = 3'd1,
        CFG_RANGE_LOW     = 3'd2,
        CFG_RANGE_HIGH    = 3'd3,
        CFG_SPEED         = 3'd4,
        CFG_TTC_THRESHOLD = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_RHS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic rhs_en;
        logic done_en;
    } t_ctrl_cmd;

    typedef logic [COS_W-1:0] t_cos_tab [0:COS_TABLE_DEPTH];

    // Table entry k is cos((pi/2)*k/depth) in Q1.15, from a Q30 Taylor series.
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab           tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 k;
        int                 n;
        for (k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x    = (Q30_HALF_PI * 64'(k)) / COS_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = Q30_ONE;
            sum  = signed'(Q30_ONE);
            for (n = 1; n <= 9; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
                if ((n & 1) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum <= 0) begin
                tab[k] = '0;
            end else begin
                sum = (sum + 64'sd16384) >>> 15;
                if (sum > 64'sd32767) begin
                    sum = 64'sd32767;
                end
                tab[k] = COS_W'(sum);
            end
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

    // Signed Q1.15 cosine of a binary angle (65536 per turn).
    function automatic logic signed [15:0] cos_q15(logic [15:0] angle);
        logic [1:0]              quad;
        logic [ANGLE_FRAC_W:0]   frac;
        logic [31:0]             i0_w;
        logic [31:0]             i1_w;
        logic [COS_IDX_W-1:0]    i0;
        logic [COS_IDX_W-1:0]    i1;
        logic signed [15:0]      c0;
        logic signed [15:0]      c1;
        quad = angle[15:14];
        frac = {1'b0, angle[ANGLE_FRAC_W-1:0]};
        i0_w = (32'(frac) * COS_TABLE_DEPTH) >> ANGLE_FRAC_W;
        i1_w = (32'((1 << ANGLE_FRAC_W) - 32'(frac)) * COS_TABLE_DEPTH) >> ANGLE_FRAC_W;
        if (i0_w > COS_TABLE_DEPTH) begin
            i0_w = COS_TABLE_DEPTH;
        end
        if (i1_w > COS_TABLE_DEPTH) begin
            i1_w = COS_TABLE_DEPTH;
        end
        i0 = COS_IDX_W'(i0_w);
        i1 = COS_IDX_W'(i1_w);
        c0 = signed'({1'b0, COS_TAB[i0]});
        c1 = signed'({1'b0, COS_TAB[i1]});
        case (quad)
            2'd0:    cos_q15 = c0;
            2'd1:    cos_q15 = -c1;
            2'd2:    cos_q15 = -c0;
            default: cos_q15 = c1;
        endcase
    endfunction

endpackage

// ===== rtl/lttc_datapath.sv =====
// Datapath of the lidar time-to-collision brake: configuration registers,
// beam angle and counter, cosine lookup, multipliers and result register. Uses lttc_pkg.
module lttc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lttc_pkg::t_ctrl_cmd                 i_cmd,
    input  logic                                i_cfg_we,
    input  logic [lttc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lttc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [lttc_pkg::RANGE_W-1:0]        i_range_mm,
    input  logic                                i_range_invalid,
    input  logic                                i_first_of_scan,
    output logic                                o_brake,
    output logic [lttc_pkg::BEAM_IDX_W-1:0]     o_beam_index
);

    logic signed [15:0]                  r_angle_start;
    logic signed [15:0]                  r_angle_step;
    logic [15:0]                         r_range_low;
    logic [15:0]                         r_range_high;
    logic signed [15:0]                  r_speed;
    logic [15:0]                         r_ttc_threshold;

    logic [15:0]                         r_angle;
    logic [15:0]                         n_angle;
    logic [lttc_pkg::BEAM_CNT_W-1:0]     r_cnt;
    logic [lttc_pkg::BEAM_CNT_W-1:0]     n_cnt;

    logic [lttc_pkg::RANGE_W-1:0]        r_range;
    logic                                r_win_ok;
    logic                                n_win_ok;
    logic signed [15:0]                  r_cos;
    logic [lttc_pkg::LHS_W-1:0]          r_lhs;
    logic signed [lttc_pkg::PROD_W-1:0]  r_prod;
    logic [lttc_pkg::RHS_W-1:0]          r_rhs;
    logic                                r_prod_pos;
    logic                                n_brake;
    logic                                r_brake;
    logic [lttc_pkg::BEAM_IDX_W-1:0]     r_beam_index;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start   <= '0;
            r_angle_step    <= '0;
            r_range_low     <= '0;
            r_range_high    <= 16'hFFFF;
            r_speed         <= '0;
            r_ttc_threshold <= 16'd1150;
        end else if (i_cfg_we) begin
            case (lttc_pkg::t_cfg_index'(i_cfg_index))
                lttc_pkg::CFG_ANGLE_START:   r_angle_start   <= signed'(i_cfg_data);
                lttc_pkg::CFG_ANGLE_STEP:    r_angle_step    <= signed'(i_cfg_data);
                lttc_pkg::CFG_RANGE_LOW:     r_range_low     <= i_cfg_data;
                lttc_pkg::CFG_RANGE_HIGH:    r_range_high    <= i_cfg_data;
                lttc_pkg::CFG_SPEED:         r_speed         <= signed'(i_cfg_data);
                lttc_pkg::CFG_TTC_THRESHOLD: r_ttc_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (i_first_of_scan) begin
            n_angle = unsigned'(r_angle_start);
            n_cnt   = '0;
        end else begin
            n_angle = r_angle + unsigned'(r_angle_step);
            if (r_cnt == lttc_pkg::BEAM_CNT_W'(lttc_pkg::MAX_BEAMS - 1)) begin
                n_cnt = '0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
        n_win_ok = !i_range_invalid && (i_range_mm >= r_range_low)
                   && (i_range_mm <= r_range_high);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.load) begin
            r_angle <= n_angle;
            r_cnt   <= n_cnt;
        end
    end

    // Payload pipeline: lookup, two multiplies, compare.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_range  <= i_range_mm;
            r_win_ok <= n_win_ok;
            r_cos    <= lttc_pkg::cos_q15(n_angle);
        end
        if (i_cmd.mul_en) begin
            r_prod <= lttc_pkg::PROD_W'(r_speed) * lttc_pkg::PROD_W'(r_cos);
            r_lhs  <= lttc_pkg::LHS_W'(r_range * lttc_pkg::LHS_W'(lttc_pkg::MM_PER_M));
        end
        if (i_cmd.rhs_en) begin
            r_prod_pos <= !r_prod[lttc_pkg::PROD_W-1] && (r_prod != '0);
            r_rhs      <= lttc_pkg::RHS_W'(r_ttc_threshold)
                          * lttc_pkg::RHS_W'(r_prod[lttc_pkg::PROD_W-2:0]);
        end
        if (i_cmd.done_en) begin
            r_brake      <= n_brake;
            r_beam_index <= lttc_pkg::BEAM_IDX_W'(32'(r_cnt));
        end
    end

    // range*1000*32768 against threshold*speed*cos.
    always_comb begin
        n_brake = r_win_ok && r_prod_pos
                  && (lttc_pkg::RHS_W'({r_lhs, 15'd0}) < r_rhs);
    end

    assign o_brake      = r_brake;
    assign o_beam_index = r_beam_index;

endmodule

// ===== rtl/lttc_ctrl.sv =====
// Controller of the lidar time-to-collision brake: sequences one word through
// the datapath and owns the output valid. Uses lttc_pkg and the assertion header.
`include "lidar_time_to_collision_brake_assert.svh"

module lttc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lttc_pkg::t_ctrl_cmd  o_cmd
);

    lttc_pkg::t_state r_state;
    lttc_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             done_fire;

    assign done_fire = (r_state == lttc_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lttc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = lttc_pkg::S_MUL;
                end
            end
            lttc_pkg::S_MUL:  n_state = lttc_pkg::S_RHS;
            lttc_pkg::S_RHS:  n_state = lttc_pkg::S_DONE;
            lttc_pkg::S_DONE: begin
                if (done_fire) begin
                    n_state = lttc_pkg::S_IDLE;
                end
            end
            default: n_state = lttc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load    = (r_state == lttc_pkg::S_IDLE) && i_in_valid;
        o_cmd.mul_en  = (r_state == lttc_pkg::S_MUL);
        o_cmd.rhs_en  = (r_state == lttc_pkg::S_RHS);
        o_cmd.done_en = done_fire;
        o_in_stall    = (r_state != lttc_pkg::S_IDLE);
        if (done_fire) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lttc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `LTTC_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == lttc_pkg::S_MUL, "accepted word did not start the sequence")
    `LTTC_ASSERT_NXT(a_done_sets_valid, i_clk, i_rst_n, done_fire, o_out_valid, "finished word not presented")
    `LTTC_ASSERT_NXT(a_blocked_holds, i_clk, i_rst_n, (r_state == lttc_pkg::S_DONE) && r_out_valid && i_out_stall, (r_state == lttc_pkg::S_DONE) && o_out_valid, "blocked result overwritten")
    `LTTC_ASSERT_IMP(a_stall_while_busy, i_clk, i_rst_n, (r_state == lttc_pkg::S_RHS) || (r_state == lttc_pkg::S_MUL), o_in_stall && !o_cmd.done_en, "busy sequence took a word")

endmodule

// ===== rtl/lidar_time_to_collision_brake.sv =====
// Lidar time-to-collision brake: one range word in, one brake word out.
// Lookup at input accept, then speed product, threshold product and compare into the output
// register. A new word is taken only once the four-step controller sequence is through with the
// last; a finished word waits in the output register while the next is taken in.
// Reset (synchronous, active low) restores register defaults and clears angle and counter.
// The cosine table is a constant ROM, so no clearing pass follows reset.
module lidar_time_to_collision_brake (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [lttc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lttc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel: one lidar beam per word.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lttc_pkg::RANGE_W-1:0]        i_range_mm,
    input  logic                                i_range_invalid,
    input  logic                                i_first_of_scan,
    // Output channel: one brake decision per word.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_brake,
    output logic [lttc_pkg::BEAM_IDX_W-1:0]     o_beam_index
);

    // The controller issues one command per cycle of the sequence: load the
    // beam (advance angle and counter, look up the cosine, check the range
    // window), form speed times cosine, form threshold times that product,
    // then compare and write the result register once the output is free.
    lttc_pkg::t_ctrl_cmd cmd;

    lttc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // The datapath holds configuration, the beam state and all arithmetic.
    // The brake test is range*1000*32768 < threshold*speed*cos, with full-width
    // products, so no division is needed.
    lttc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_range_mm      (i_range_mm),
        .i_range_invalid (i_range_invalid),
        .i_first_of_scan (i_first_of_scan),
        .o_brake         (o_brake),
        .o_beam_index    (o_beam_index)
    );

endmodule

// ===== bench/lidar_time_to_collision_brake_tb.sv =====
// Self-checking testbench for the lidar time-to-collision brake block.
// Depends on rtl/lttc_pkg.sv for port widths and register indexes, and on
// the lidar_time_to_collision_brake module itself.
module lidar_time_to_collision_brake_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Sizes of the brake logic as the predictor sees them.
    localparam int COS_DEPTH   = 256;
    localparam int BEAM_WRAP   = 4096;
    localparam int DUT_LATENCY = 3;

    // The watchdog ends the run after this many cycles with no word moving on
    // either channel. The longest honest quiet spell is a sender gap, a
    // receiver stall and a few register writes, all far shorter than this limit.
    localparam int IDLE_LIMIT = 5000;
    localparam int MAX_GAP    = 12;
    localparam int PRINT_CAP  = 100;

    localparam logic [63:0] Q30_UNIT         = 64'd1 << 30;
    localparam logic [63:0] Q30_QUARTER_TURN = 64'd1686629713;

    // Register indexes past the last register; the block must ignore writes there.
    localparam logic [lttc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [lttc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                               brake;
        logic [lttc_pkg::BEAM_IDX_W-1:0]    beam_index;
    } decision_t;

    typedef struct packed {
        logic [15:0] angle_start;
        logic [15:0] angle_step;
        logic [15:0] range_low;
        logic [15:0] range_high;
        logic [15:0] speed;
        logic [15:0] threshold;
    } ttc_regs_t;

    localparam ttc_regs_t REGS_AT_RESET = '{
        angle_start: 16'd0, angle_step: 16'd0, range_low: 16'd0,
        range_high: 16'hFFFF, speed: 16'd0, threshold: 16'd1150
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [lttc_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [lttc_pkg::CFG_DATA_W-1:0]    i_cfg_data;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic [lttc_pkg::RANGE_W-1:0]       i_range_mm;
    logic                               i_range_invalid;
    logic                               i_first_of_scan;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic                               o_brake;
    logic [lttc_pkg::BEAM_IDX_W-1:0]    o_beam_index;

    // Predictor state: a shadow of the registers, the beam angle and counter,
    // and the quarter-wave cosine table in Q1.15.
    ttc_regs_t      regs;
    logic [15:0]    model_angle;
    int             model_count;
    int             cos_rom [0:COS_DEPTH];

    // Brake decisions predicted for accepted beams, oldest first.
    decision_t      pending_decisions[$];

    int             mismatch_count = 0;
    int             idle_cycles    = 0;
    int             burst_left     = 0;
    int             stall_left     = 0;

    lidar_time_to_collision_brake dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_range_mm      (i_range_mm),
        .i_range_invalid (i_range_invalid),
        .i_first_of_scan (i_first_of_scan),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_brake         (o_brake),
        .o_beam_index    (o_beam_index)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The cosine table holds cos((pi/2)*k/depth) for k = 0..depth, worked out
    // with a ten-term Taylor series in Q30 and rounded to Q1.15. Entries that
    // come out at or below zero are stored as zero, and the top is held at 32767.
    function automatic void fill_cos_rom();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            x    = (Q30_QUARTER_TURN * 64'(k)) / 64'(COS_DEPTH);
            x2   = (x * x) >> 30;
            term = Q30_UNIT;
            acc  = longint'(Q30_UNIT);
            for (int n = 1; n <= 9; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc <= 0) begin
                cos_rom[k] = 0;
            end else begin
                acc        = (acc + 16384) >>> 15;
                cos_rom[k] = (acc > 32767) ? 32767 : int'(acc);
            end
        end
    endfunction

    // Signed cosine of a binary angle. The low 14 bits pick a table entry; in
    // the second and fourth quadrants the entry is read from the far end.
    function automatic int cos_of_angle(logic [15:0] a);
        int frac;
        int near_idx;
        int far_idx;
        frac     = int'(a[13:0]);
        near_idx = (frac * COS_DEPTH) >> 14;
        far_idx  = ((16384 - frac) * COS_DEPTH) >> 14;
        if (near_idx > COS_DEPTH) begin
            near_idx = COS_DEPTH;
        end
        if (far_idx > COS_DEPTH) begin
            far_idx = COS_DEPTH;
        end
        case (a[15:14])
            2'd0:    return cos_rom[near_idx];
            2'd1:    return -cos_rom[far_idx];
            2'd2:    return -cos_rom[near_idx];
            default: return cos_rom[far_idx];
        endcase
    endfunction

    // Advances the beam angle and counter for one accepted beam and decides
    // whether it asks for braking. Braking needs a valid reading inside the
    // range window and a positive closing speed (speed times cosine); then
    // range*1000*32768 < threshold*speed*cos, compared at full width.
    function automatic decision_t predict_decision(logic [15:0] range_mm, logic invalid,
                                                   logic first_beam);
        decision_t   d;
        longint      closing;
        logic [63:0] lhs;
        logic [63:0] rhs;
        if (first_beam) begin
            model_angle = regs.angle_start;
            model_count = 0;
        end else begin
            model_angle = model_angle + regs.angle_step;
            model_count = (model_count + 1) % BEAM_WRAP;
        end
        d.brake = 1'b0;
        if (!invalid && range_mm >= regs.range_low && range_mm <= regs.range_high) begin
            closing = longint'($signed(regs.speed)) * longint'(cos_of_angle(model_angle));
            if (closing > 0) begin
                lhs     = 64'(range_mm) * 64'd1000 * 64'd32768;
                rhs     = 64'(regs.threshold) * 64'(closing);
                d.brake = (lhs < rhs);
            end
        end
        d.beam_index = model_count[lttc_pkg::BEAM_IDX_W-1:0];
        return d;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Output side: every word taken from the block is matched against the
    // oldest prediction, field by field. Values are read just after the edge,
    // before any nonblocking update of that edge, so they are the ones the
    // block saw.
    always @(posedge i_clk) begin : check_results
        decision_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_decisions.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: brake=%0b index=%0d",
                                          o_brake, o_beam_index));
            end else begin
                want = pending_decisions.pop_front();
                if (o_brake !== want.brake) begin
                    report_mismatch($sformatf("beam %0d: brake %0b, expected %0b",
                                              want.beam_index, o_brake, want.brake));
                end
                if (o_beam_index !== want.beam_index) begin
                    report_mismatch($sformatf("beam_index %0d, expected %0d",
                                              o_beam_index, want.beam_index));
                end
            end
        end
    end

    // Receiver back-pressure: long clear stretches, solid stalls and short
    // spells of noisy stalling, in random order.
    always @(posedge i_clk) begin : stall_pattern
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    i_out_stall <= 1'b0;
                    stall_left  = $urandom_range(20, 60);
                end
                1: begin
                    i_out_stall <= 1'b1;
                    stall_left  = $urandom_range(1, 12);
                end
                default: begin
                    i_out_stall <= 1'($urandom_range(0, 1));
                    stall_left  = $urandom_range(0, 2);
                end
            endcase
        end
    end

    // Watchdog: a hung handshake on either side ends the run as a failure.
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL lidar_time_to_collision_brake");
            $finish;
        end
    end

    // Offers one beam and holds it until the block takes it, then records the
    // prediction. Valid is left high for the next word unless the current
    // burst is over, in which case a random gap follows.
    task automatic send_beam(logic [15:0] range_mm, logic invalid, logic first_beam);
        int gap;
        i_in_valid      <= 1'b1;
        i_range_mm      <= range_mm;
        i_range_invalid <= invalid;
        i_first_of_scan <= first_beam;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_decisions.push_back(predict_decision(range_mm, invalid, first_beam));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
            gap        = $urandom_range(1, MAX_GAP);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Ranges lean toward the braking region and the window edges, with some
    // drawn across the whole field. About one beam in ten is invalid.
    task automatic send_random_beam(logic first_beam);
        logic [15:0] r;
        case ($urandom_range(0, 4))
            0:       r = 16'($urandom_range(0, 65535));
            1, 2:    r = 16'($urandom_range(0, 3000));
            3:       r = regs.range_low + 16'($urandom_range(0, 2)) - 16'd1;
            default: r = regs.range_high + 16'($urandom_range(0, 2)) - 16'd1;
        endcase
        send_beam(r, $urandom_range(0, 9) == 0, first_beam);
    endtask

    // Each register write drops the write enable again and lets the block see it low, so that the
    // write enable is never lowered and raised within one step.
    task automatic write_reg(logic [lttc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            lttc_pkg::CFG_ANGLE_START:   regs.angle_start = val;
            lttc_pkg::CFG_ANGLE_STEP:    regs.angle_step  = val;
            lttc_pkg::CFG_RANGE_LOW:     regs.range_low   = val;
            lttc_pkg::CFG_RANGE_HIGH:    regs.range_high  = val;
            lttc_pkg::CFG_SPEED:         regs.speed       = val;
            lttc_pkg::CFG_TTC_THRESHOLD: regs.threshold   = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(ttc_regs_t s);
        write_reg(lttc_pkg::CFG_ANGLE_START, s.angle_start);
        write_reg(lttc_pkg::CFG_ANGLE_STEP, s.angle_step);
        write_reg(lttc_pkg::CFG_RANGE_LOW, s.range_low);
        write_reg(lttc_pkg::CFG_RANGE_HIGH, s.range_high);
        write_reg(lttc_pkg::CFG_SPEED, s.speed);
        write_reg(lttc_pkg::CFG_TTC_THRESHOLD, s.threshold);
    endtask

    // Drops valid, waits for every predicted word to come back, then lets the
    // pipeline settle so that register writes land on an idle block.
    task automatic wait_idle();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        while (pending_decisions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DUT_LATENCY * 2) @(posedge i_clk);
    endtask

    function automatic ttc_regs_t random_settings();
        ttc_regs_t s;
        s.angle_start = 16'($urandom);
        s.angle_step  = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                    : 16'(16'($urandom_range(0, 2048))
                                                      * (($urandom_range(0, 1) == 0) ? 1 : -1));
        s.range_low   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 500));
        s.range_high  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'hFFFF - 16'($urandom_range(0, 1000));
        s.speed       = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(1, 32767));
        s.threshold   = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(200, 5000));
        return s;
    endfunction

    // Straight out of reset, with no scan start seen: the angle begins at
    // zero, the counter counts up from zero, and zero speed never brakes.
    task automatic test_reset_state();
        send_beam(16'd0, 1'b0, 1'b0);
        send_beam(16'hFFFF, 1'b0, 1'b0);
        send_beam(16'd1234, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Range extremes, an invalid reading, both edges of the window, and an
    // empty window where the low bound sits above the high bound.
    task automatic test_range_window();
        load_settings('{angle_start: 16'd0, angle_step: 16'd0, range_low: 16'd0,
                        range_high: 16'hFFFF, speed: 16'd32767, threshold: 16'hFFFF});
        send_beam(16'd0, 1'b0, 1'b1);
        send_beam(16'hFFFF, 1'b0, 1'b0);
        send_beam(16'd0, 1'b1, 1'b0);
        wait_idle();
        write_reg(lttc_pkg::CFG_RANGE_LOW, 16'd100);
        write_reg(lttc_pkg::CFG_RANGE_HIGH, 16'd200);
        send_beam(16'd99, 1'b0, 1'b0);
        send_beam(16'd100, 1'b0, 1'b0);
        send_beam(16'd200, 1'b0, 1'b0);
        send_beam(16'd201, 1'b0, 1'b0);
        wait_idle();
        write_reg(lttc_pkg::CFG_RANGE_LOW, 16'd500);
        write_reg(lttc_pkg::CFG_RANGE_HIGH, 16'd400);
        send_beam(16'd450, 1'b0, 1'b1);
        wait_idle();
    endtask

    // Walks a quarter turn at a time from the back of the vehicle with full
    // reverse speed, so the cosine sign and the zero at each quadrant boundary
    // all show, then steps one unit across the first quadrant boundary.
    task automatic test_quadrants();
        load_settings('{angle_start: 16'h8000, angle_step: 16'h4000, range_low: 16'd0,
                        range_high: 16'hFFFF, speed: 16'h8000, threshold: 16'hFFFF});
        send_beam(16'd1000, 1'b0, 1'b1);
        send_beam(16'd1000, 1'b0, 1'b0);
        send_beam(16'd1000, 1'b0, 1'b0);
        send_beam(16'd1000, 1'b0, 1'b0);
        wait_idle();
        write_reg(lttc_pkg::CFG_ANGLE_START, 16'h3FFF);
        write_reg(lttc_pkg::CFG_ANGLE_STEP, 16'd1);
        write_reg(lttc_pkg::CFG_SPEED, 16'd32767);
        send_beam(16'd100, 1'b0, 1'b1);
        send_beam(16'd100, 1'b0, 1'b0);
        wait_idle();
    endtask

    // A zero threshold never brakes, zero speed is skipped, the smallest
    // positive speed still brakes at zero range, and the farthest range
    // brakes at the largest threshold and speed.
    task automatic test_threshold_and_speed();
        load_settings('{angle_start: 16'd0, angle_step: 16'd0, range_low: 16'd0,
                        range_high: 16'hFFFF, speed: 16'd32767, threshold: 16'd0});
        send_beam(16'd0, 1'b0, 1'b1);
        wait_idle();
        write_reg(lttc_pkg::CFG_TTC_THRESHOLD, 16'hFFFF);
        write_reg(lttc_pkg::CFG_SPEED, 16'd0);
        send_beam(16'd0, 1'b0, 1'b0);
        wait_idle();
        write_reg(lttc_pkg::CFG_SPEED, 16'd1);
        write_reg(lttc_pkg::CFG_TTC_THRESHOLD, 16'd1);
        send_beam(16'd0, 1'b0, 1'b0);
        wait_idle();
        write_reg(lttc_pkg::CFG_SPEED, 16'd32767);
        write_reg(lttc_pkg::CFG_TTC_THRESHOLD, 16'hFFFF);
        send_beam(16'hFFFF, 1'b0, 1'b1);
        wait_idle();
    endtask

    // Writes past the last register must leave every setting untouched.
    task automatic test_spare_register_index();
        write_reg(CFG_IDX_SPARE_LO, 16'hFFFF);
        write_reg(CFG_IDX_SPARE_HI, 16'h0000);
        send_beam(16'd2000, 1'b0, 1'b1);
        send_beam(16'd2000, 1'b0, 1'b0);
        wait_idle();
    endtask

    // Random scans under several settings. The first three phases pin the
    // registers at fixed, mostly extreme values; the rest draw them at random. Most beams
    // belong to proper scans, with the odd stray scan start as noise.
    task automatic test_random_scans();
        ttc_regs_t s;
        int        sent;
        int        len;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: s = '{angle_start: 16'h7FFF, angle_step: 16'h7FFF, range_low: 16'd0,
                         range_high: 16'hFFFF, speed: 16'h7FFF, threshold: 16'hFFFF};
                1: s = '{angle_start: 16'h8000, angle_step: 16'h8000, range_low: 16'd0,
                         range_high: 16'd0, speed: 16'h8000, threshold: 16'd0};
                2: s = '{angle_start: 16'd0, angle_step: 16'd256, range_low: 16'hFFFF,
                         range_high: 16'hFFFF, speed: 16'h7FFF, threshold: 16'hFFFF};
                default: s = random_settings();
            endcase
            wait_idle();
            load_settings(s);
            sent = 0;
            while (sent < 85) begin
                len = $urandom_range(1, 40);
                send_random_beam(1'b1);
                for (int b = 0; b < len; b++) begin
                    send_random_beam($urandom_range(0, 19) == 0);
                end
                sent += len + 1;
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= lttc_pkg::CFG_ANGLE_START;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_range_mm      <= '0;
        i_range_invalid <= 1'b0;
        i_first_of_scan <= 1'b0;
        fill_cos_rom();
        regs        = REGS_AT_RESET;
        model_angle = '0;
        model_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_range_window();
        test_quadrants();
        test_threshold_and_speed();
        test_spare_register_index();
        test_random_scans();

        wait_idle();
        repeat (DUT_LATENCY * 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS lidar_time_to_collision_brake");
        end else begin
            $display("FAIL lidar_time_to_collision_brake");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lttc_pkg.sv
rtl/lttc_datapath.sv
rtl/lttc_ctrl.sv
rtl/lidar_time_to_collision_brake.sv
bench/lidar_time_to_collision_brake_tb.sv
